// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: codes, widths and helper functions.
`default_nettype none
package rau_pkg;

  localparam int RES_W = 64;
  localparam int DEF_OPERAND_WIDTH = 32;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // magnitude of a signed word as an unsigned word (most negative value maps to 2^63)
  function automatic logic [RES_W-1:0] mag(input logic [RES_W-1:0] x);
    mag = x[RES_W-1] ? (~x + RES_W'(1)) : x;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rau_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module rau_div #(
  parameter int W = rau_pkg::RES_W
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== hdl/rational_arith_unit.sv =====
// Top level: fraction add/sub/mul/div/compare with gcd reduction on a shared divider.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid/in_ready, in_action, in_a_*, in_b_*  | in
//  result  | out_valid/out_ready, out_res_*, out_less, ... | out
//
// Four products go through one shared combinational multiplier in turn, each product
// registered, then the evaluate state. gcd reduction runs Euclid remainder steps on a
// bit-serial divider, plus two final divisions; total is data dependent.
// Errors, compare and unused actions skip gcd and go from evaluate to the result state.
// in_ready is high only when idle; a held result stalls the next transaction in S_FIN.
// Synchronous active-low reset clears control state only.
`default_nettype none
module rational_arith_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic signed [31:0] in_a_numerator,
  input  wire logic signed [31:0] in_a_denominator,
  input  wire logic signed [31:0] in_b_numerator,
  input  wire logic signed [31:0] in_b_denominator,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [63:0] out_res_numerator,
  output logic signed [63:0] out_res_denominator,
  output logic             out_less,
  output logic             out_equal,
  output logic [1:0]       out_status
);

  localparam int OW = OPERAND_WIDTH;
  localparam int RW = rau_pkg::RES_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_EVAL   = 9'b000000100,
    S_GCD    = 9'b000001000,
    S_GWAIT  = 9'b000010000,
    S_NWAIT  = 9'b000100000,
    S_DSTART = 9'b001000000,
    S_DWAIT  = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state_r;

  logic [2:0]           act_r;
  logic signed [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic [1:0]           mcnt_r;
  logic signed [RW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [RW-1:0] num_r, den_r;
  logic                 e1_neg_r, e2_neg_r;
  logic [RW-1:0]        e1_mag_r, e2_mag_r;
  logic signed [RW-1:0] rnum_r, rden_r;
  logic                 less_r, equal_r, novf_r;
  logic [1:0]           st_r;

  logic                 out_valid_r;
  logic signed [RW-1:0] out_num_r, out_den_r;
  logic                 out_less_r, out_equal_r;
  logic [1:0]           out_status_r;

  // shared multiplier
  logic signed [OW-1:0]   mul_x, mul_y;
  logic signed [2*OW-1:0] mul_p;
  logic signed [RW-1:0]   prod;

  always_comb begin
    case (mcnt_r)
      2'd0: begin mul_x = an_r; mul_y = bd_r; end
      2'd1: begin mul_x = bn_r; mul_y = ad_r; end
      2'd2: begin mul_x = ad_r; mul_y = (act_r == rau_pkg::ACT_DIV) ? bn_r : bd_r; end
      default: begin mul_x = an_r; mul_y = bn_r; end
    endcase
  end
  assign mul_p = mul_x * mul_y;
  assign prod  = RW'(mul_p);

  // evaluate
  logic [RW:0] sum;
  logic        sum_ovf, zero_den, pos, cmp_less, cmp_eq, act_bad;
  logic        eval_cmp, eval_ovf, eval_gcd;
  logic [1:0]  eval_st;
  logic signed [RW-1:0] num_sel;

  assign sum = {p1_r[RW-1], p1_r} + ((act_r == rau_pkg::ACT_SUB) ?
               -{p2_r[RW-1], p2_r} : {p2_r[RW-1], p2_r});
  assign sum_ovf  = !sum[RW] && sum[RW-1];
  assign zero_den = (ad_r == '0) || (bd_r == '0) ||
                    ((act_r == rau_pkg::ACT_DIV) && (bn_r == '0));
  assign pos      = (ad_r[OW-1] == bd_r[OW-1]);
  assign cmp_less = pos ? (p1_r < p2_r) : (p1_r > p2_r);
  assign cmp_eq   = (p1_r == p2_r);
  assign act_bad  = act_r > rau_pkg::ACT_CMP;

  assign eval_cmp = !act_bad && !zero_den && (act_r == rau_pkg::ACT_CMP);
  assign eval_ovf = !act_bad && !zero_den && sum_ovf &&
                    ((act_r == rau_pkg::ACT_ADD) || (act_r == rau_pkg::ACT_SUB));
  assign eval_gcd = !act_bad && !zero_den && !eval_ovf && (act_r != rau_pkg::ACT_CMP);
  assign eval_st  = act_bad  ? rau_pkg::ST_OK :
                    zero_den ? rau_pkg::ST_ZERO_DEN :
                    eval_ovf ? rau_pkg::ST_OVERFLOW : rau_pkg::ST_OK;

  always_comb begin
    case (act_r)
      rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: num_sel = sum[RW-1:0];
      rau_pkg::ACT_MUL: num_sel = p4_r;
      default:          num_sel = p1_r;
    endcase
  end

  // divider hookup
  logic          e1_zero, div_start, div_busy, div_done;
  logic [RW-1:0] num_mag, den_mag, div_dvd, div_dvs, div_quo, div_rem;
  logic          q_neg, q_ovf;
  logic [RW-1:0] q_signed;
  logic          fin_load;

  assign e1_zero   = (e1_mag_r == '0);
  assign num_mag   = rau_pkg::mag(num_r);
  assign den_mag   = rau_pkg::mag(den_r);
  assign div_start = (state_r == S_GCD) || (state_r == S_DSTART);
  assign div_dvd   = (state_r == S_DSTART) ? den_mag : (e1_zero ? num_mag : e2_mag_r);
  assign div_dvs   = ((state_r == S_DSTART) || e1_zero) ? e2_mag_r : e1_mag_r;

  rau_div #(.W(RW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // final quotient sign: dividend sign differs from gcd sign
  assign q_neg    = ((state_r == S_DWAIT) ? den_r[RW-1] : num_r[RW-1]) != e2_neg_r;
  assign q_signed = q_neg ? (~div_quo + RW'(1)) : div_quo;
  assign q_ovf    = !q_neg && div_quo[RW-1];

  assign in_ready = (state_r == S_IDLE);
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r   <= in_action;
            an_r    <= in_a_numerator[OW-1:0];
            ad_r    <= in_a_denominator[OW-1:0];
            bn_r    <= in_b_numerator[OW-1:0];
            bd_r    <= in_b_denominator[OW-1:0];
            mcnt_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          case (mcnt_r)
            2'd0:    p1_r <= prod;
            2'd1:    p2_r <= prod;
            2'd2:    p3_r <= prod;
            default: p4_r <= prod;
          endcase
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) state_r <= S_EVAL;
        end
        S_EVAL: begin
          rnum_r  <= '0;
          rden_r  <= RW'(1);
          less_r  <= eval_cmp && cmp_less;
          equal_r <= eval_cmp && cmp_eq;
          st_r    <= eval_st;
          novf_r  <= 1'b0;
          if (eval_gcd) begin
            num_r    <= num_sel;
            den_r    <= p3_r;
            e1_neg_r <= num_sel[RW-1];
            e1_mag_r <= rau_pkg::mag(num_sel);
            e2_neg_r <= p3_r[RW-1];
            e2_mag_r <= rau_pkg::mag(p3_r);
            state_r  <= S_GCD;
          end else begin
            state_r  <= S_FIN;
          end
        end
        S_GCD: begin
          // e1 zero: gcd is e2, start reducing the numerator
          state_r <= e1_zero ? S_NWAIT : S_GWAIT;
        end
        S_GWAIT: begin
          if (div_done) begin
            e1_mag_r <= div_rem;
            e1_neg_r <= e2_neg_r;
            e2_mag_r <= e1_mag_r;
            e2_neg_r <= e1_neg_r;
            state_r  <= S_GCD;
          end
        end
        S_NWAIT: begin
          if (div_done) begin
            rnum_r  <= q_signed;
            novf_r  <= q_ovf;
            state_r <= S_DSTART;
          end
        end
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            if (novf_r || q_ovf) begin
              st_r   <= rau_pkg::ST_OVERFLOW;
              rnum_r <= '0;
              rden_r <= RW'(1);
            end else begin
              rden_r <= q_signed;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_num_r    <= rnum_r;
            out_den_r    <= rden_r;
            out_less_r   <= less_r;
            out_equal_r  <= equal_r;
            out_status_r <= st_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_res_numerator   = out_num_r;
  assign out_res_denominator = out_den_r;
  assign out_less            = out_less_r;
  assign out_equal           = out_equal_r;
  assign out_status          = out_status_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("divider busy while idle");

  a_ovf_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == rau_pkg::ST_OVERFLOW)) |->
    ((out_res_numerator == '0) && (out_res_denominator == RW'(1))))
    else $error("overflow result not fixed");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_valid && !out_ready) |=> (state_r == S_FIN))
    else $error("result overwrote a pending transaction");

endmodule
`default_nettype wire
